// File: sv/rfd_pkg.sv
package rfd_pkg;

  localparam int unsigned CMP_W = 10;

  localparam logic [CMP_W-1:0] HDR_BYTES       = CMP_W'(11);
  localparam logic [CMP_W-1:0] MIN_FRAME_BYTES = CMP_W'(12);
  localparam logic [31:0]      BCAST_ADDR      = 32'hFFFF_FFFF;

  localparam logic [CMP_W-1:0] POS_TYPE  = CMP_W'(0);
  localparam logic [CMP_W-1:0] POS_SRC0  = CMP_W'(1);
  localparam logic [CMP_W-1:0] POS_SRC1  = CMP_W'(2);
  localparam logic [CMP_W-1:0] POS_SRC2  = CMP_W'(3);
  localparam logic [CMP_W-1:0] POS_SRC3  = CMP_W'(4);
  localparam logic [CMP_W-1:0] POS_DST0  = CMP_W'(5);
  localparam logic [CMP_W-1:0] POS_DST1  = CMP_W'(6);
  localparam logic [CMP_W-1:0] POS_DST2  = CMP_W'(7);
  localparam logic [CMP_W-1:0] POS_DST3  = CMP_W'(8);
  localparam logic [CMP_W-1:0] POS_SEQ   = CMP_W'(9);
  localparam logic [CMP_W-1:0] POS_LEN   = CMP_W'(10);

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic REG_NODE_ADDR = 1'b0;

  typedef enum logic [2:0] {
    ST_ACCEPTED     = 3'd0,
    ST_TOO_SHORT    = 3'd1,
    ST_TRUNCATED    = 3'd2,
    ST_BAD_CHECKSUM = 3'd3,
    ST_WRONG_DEST   = 3'd4
  } rfd_status_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    rfd_status_e frame_status;
    logic [7:0]  frame_type;
    logic [31:0] source_address;
    logic [7:0]  sequence_number;
    logic [7:0]  payload_length;
    logic        is_broadcast;
    logic [31:0] accepted_frames;
    logic        last_of_run;
  } rfd_result_t;

  typedef struct packed {
    logic [1:0]  cnt;
    rfd_result_t first;
    rfd_result_t second;
  } rfd_push_t;

endpackage

// File: sv/rfd_parser.sv
module rfd_parser #(
  parameter int unsigned MAX_FRAME_BYTES = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             beat_i,
  input  logic [7:0]       rx_byte_i,
  input  logic             frame_end_i,
  input  logic [31:0]      node_address_i,
  output rfd_pkg::rfd_push_t push_o
);
  import rfd_pkg::*;

  localparam int unsigned PosW = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [CMP_W-1:0] MaxPos = CMP_W'(MAX_FRAME_BYTES);

  logic [PosW-1:0] pos_q, pos_d, pos_n;
  logic [7:0]      xor_q, xor_d, xor_n;
  logic [7:0]      type_q, type_d, type_n;
  logic [31:0]     src_q, src_d, src_n;
  logic [31:0]     dst_q, dst_d, dst_n;
  logic [7:0]      seq_q, seq_d, seq_n;
  logic [7:0]      len_q, len_d, len_n;
  logic [7:0]      cks_q, cks_d, cks_n;
  logic [31:0]     cnt_q, cnt_d;

  logic [CMP_W-1:0] pos_x, cks_pos, pos_nx;
  logic             in_range, is_payload, bcast;
  rfd_status_e      status;
  rfd_result_t      pay_res, st_res;

  always_comb begin
    pos_x      = CMP_W'(pos_q);
    cks_pos    = HDR_BYTES + CMP_W'(len_q);
    in_range   = pos_x < MaxPos;
    is_payload = 1'b0;
    pos_n      = pos_q;
    xor_n      = xor_q;
    type_n     = type_q;
    src_n      = src_q;
    dst_n      = dst_q;
    seq_n      = seq_q;
    len_n      = len_q;
    cks_n      = cks_q;
    if (in_range) begin
      pos_n = pos_q + PosW'(1);
      if (pos_x < HDR_BYTES) begin
        xor_n = xor_q ^ rx_byte_i;
      end
      unique case (pos_x)
        POS_TYPE: type_n        = rx_byte_i;
        POS_SRC0: src_n[31:24]  = src_q[31:24] | rx_byte_i;
        POS_SRC1: src_n[23:16]  = src_q[23:16] | rx_byte_i;
        POS_SRC2: src_n[15:8]   = src_q[15:8]  | rx_byte_i;
        POS_SRC3: src_n[7:0]    = src_q[7:0]   | rx_byte_i;
        POS_DST0: dst_n[31:24]  = dst_q[31:24] | rx_byte_i;
        POS_DST1: dst_n[23:16]  = dst_q[23:16] | rx_byte_i;
        POS_DST2: dst_n[15:8]   = dst_q[15:8]  | rx_byte_i;
        POS_DST3: dst_n[7:0]    = dst_q[7:0]   | rx_byte_i;
        POS_SEQ:  seq_n         = rx_byte_i;
        POS_LEN:  len_n         = rx_byte_i;
        default: begin
          if (pos_x < cks_pos) begin
            xor_n      = xor_q ^ rx_byte_i;
            is_payload = 1'b1;
          end else if (pos_x == cks_pos) begin
            cks_n = rx_byte_i;
          end
        end
      endcase
    end

    pos_nx = CMP_W'(pos_n);
    bcast  = dst_n == BCAST_ADDR;
    if (pos_nx < MIN_FRAME_BYTES) begin
      status = ST_TOO_SHORT;
    end else if (pos_nx < MIN_FRAME_BYTES + CMP_W'(len_n)) begin
      status = ST_TRUNCATED;
    end else if (xor_n != cks_n) begin
      status = ST_BAD_CHECKSUM;
    end else if (dst_n != node_address_i && !bcast) begin
      status = ST_WRONG_DEST;
    end else begin
      status = ST_ACCEPTED;
    end

    cnt_d = cnt_q;
    if (beat_i && frame_end_i && status == ST_ACCEPTED) begin
      cnt_d = cnt_q + 32'd1;
    end

    pay_res              = '0;
    pay_res.kind         = KIND_PAYLOAD;
    pay_res.payload_byte = rx_byte_i;
    pay_res.frame_status = ST_ACCEPTED;
    pay_res.last_of_run  = !frame_end_i;

    st_res.kind            = KIND_STATUS;
    st_res.payload_byte    = 8'd0;
    st_res.frame_status    = status;
    st_res.frame_type      = type_n;
    st_res.source_address  = src_n;
    st_res.sequence_number = seq_n;
    st_res.payload_length  = len_n;
    st_res.is_broadcast    = bcast;
    st_res.accepted_frames = cnt_d;
    st_res.last_of_run     = 1'b1;

    push_o.cnt    = 2'd0;
    push_o.first  = st_res;
    push_o.second = st_res;
    if (beat_i) begin
      if (is_payload) begin
        push_o.first = pay_res;
        push_o.cnt   = frame_end_i ? 2'd2 : 2'd1;
      end else if (frame_end_i) begin
        push_o.cnt = 2'd1;
      end
    end

    pos_d  = pos_q;
    xor_d  = xor_q;
    type_d = type_q;
    src_d  = src_q;
    dst_d  = dst_q;
    seq_d  = seq_q;
    len_d  = len_q;
    cks_d  = cks_q;
    if (beat_i) begin
      if (frame_end_i) begin
        pos_d  = '0;
        xor_d  = '0;
        type_d = '0;
        src_d  = '0;
        dst_d  = '0;
        seq_d  = '0;
        len_d  = '0;
        cks_d  = '0;
      end else begin
        pos_d  = pos_n;
        xor_d  = xor_n;
        type_d = type_n;
        src_d  = src_n;
        dst_d  = dst_n;
        seq_d  = seq_n;
        len_d  = len_n;
        cks_d  = cks_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      xor_q  <= '0;
      type_q <= '0;
      src_q  <= '0;
      dst_q  <= '0;
      seq_q  <= '0;
      len_q  <= '0;
      cks_q  <= '0;
      cnt_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      xor_q  <= xor_d;
      type_q <= type_d;
      src_q  <= src_d;
      dst_q  <= dst_d;
      seq_q  <= seq_d;
      len_q  <= len_d;
      cks_q  <= cks_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// File: sv/rfd_outq.sv
module rfd_outq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rfd_pkg::rfd_push_t   push_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic                 full_o,
  output rfd_pkg::rfd_result_t head_o
);
  import rfd_pkg::*;

  localparam int unsigned Depth = 3;

  rfd_result_t ent_q [Depth];
  rfd_result_t ent_d [Depth];
  logic [1:0]  count_q, count_d, base;
  logic        pop;

  assign out_valid_o = count_q != 2'd0;
  assign full_o      = count_q > 2'd1;
  assign head_o      = ent_q[0];
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    base = count_q - {1'b0, pop};
    for (int i = 0; i < Depth; i++) begin
      if (pop && i < Depth - 1) begin
        ent_d[i] = ent_q[i+1];
      end else begin
        ent_d[i] = ent_q[i];
      end
      if (push_i.cnt != 2'd0 && base == 2'(i)) begin
        ent_d[i] = push_i.first;
      end
      if (push_i.cnt == 2'd2 && base + 2'd1 == 2'(i)) begin
        ent_d[i] = push_i.second;
      end
    end
    count_d = base + push_i.cnt;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      ent_q[i] <= ent_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'd3)
    else $error("queue count out of range");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt != 2'd0 |-> count_q <= 2'd1)
    else $error("push without room for two results");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 count_q == $past(count_q) - {1'b0, $past(pop)} + $past(push_i.cnt))
    else $error("queue count does not track push and pop");

endmodule

// File: sv/radio_frame_deframer.sv
// Radio frame deframer.
// Input channel: one received frame byte per beat (rx_byte_i) with frame_end_i
// on the last byte; a beat is taken when in_valid_i is high and in_stall_o low.
// Output channel: one result per beat, taken when out_valid_o is high and
// out_stall_i low. kind_o 0 is a payload byte, kind_o 1 the end-of-frame
// status with header fields, broadcast flag and the accepted frame count.
// A payload byte on the final input beat yields two results, payload first.
// Throughput is one byte per cycle while in_stall_o is low; the frame state
// and checksum update in a single registered pass. The three-entry result
// queue raises in_stall_o once it holds two or more results, so an input
// beat always has room for both of its results. When the receiver stalls
// the queue fills and the input side stalls in turn. Reset clears the frame
// state, the accepted counter, node_address and the queue. node_address sits
// at APB address 0. The user must write it only while idle; the block itself
// does not enforce this.
module radio_frame_deframer #(
  parameter int unsigned MAX_FRAME_BYTES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [2:0]  frame_status_o,
  output logic [7:0]  frame_type_o,
  output logic [31:0] source_address_o,
  output logic [7:0]  sequence_number_o,
  output logic [7:0]  payload_length_o,
  output logic        is_broadcast_o,
  output logic [31:0] accepted_frames_o,
  output logic        last_of_run_o
);
  import rfd_pkg::*;

  logic [31:0] node_addr_q, node_addr_d;
  logic        beat, full;
  rfd_push_t   push;
  rfd_result_t head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_NODE_ADDR) ? node_addr_q : 32'd0;

  always_comb begin
    node_addr_d = node_addr_q;
    if (psel && penable && pwrite && paddr[2] == REG_NODE_ADDR) begin
      node_addr_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_addr_q <= '0;
    end else begin
      node_addr_q <= node_addr_d;
    end
  end

  assign in_stall_o = full;
  assign beat       = in_valid_i && !full;

  rfd_parser #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .beat_i         (beat),
    .rx_byte_i      (rx_byte_i),
    .frame_end_i    (frame_end_i),
    .node_address_i (node_addr_q),
    .push_o         (push)
  );

  rfd_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .full_o      (full),
    .head_o      (head)
  );

  assign kind_o            = head.kind;
  assign payload_byte_o    = head.payload_byte;
  assign frame_status_o    = head.frame_status;
  assign frame_type_o      = head.frame_type;
  assign source_address_o  = head.source_address;
  assign sequence_number_o = head.sequence_number;
  assign payload_length_o  = head.payload_length;
  assign is_broadcast_o    = head.is_broadcast;
  assign accepted_frames_o = head.accepted_frames;
  assign last_of_run_o     = head.last_of_run;

endmodule

// File: dv/rfd_frame_checker.sv
module rfd_frame_checker #(
  parameter int MAX_BYTES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_end_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic        kind_o,
  input  logic [7:0]  payload_byte_o,
  input  logic [2:0]  frame_status_o,
  input  logic [7:0]  frame_type_o,
  input  logic [31:0] source_address_o,
  input  logic [7:0]  sequence_number_o,
  input  logic [7:0]  payload_length_o,
  input  logic        is_broadcast_o,
  input  logic [31:0] accepted_frames_o,
  input  logic        last_of_run_o,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o,
  output int          accepted_o
);
  import rfd_pkg::*;

  localparam logic [2:0] NODE_ADDR_OFFSET = {REG_NODE_ADDR, 2'b00};

  logic [31:0] node_addr = '0;
  logic [8:0]  frame_pos = '0;
  logic [7:0]  frame_xor = '0;
  logic [7:0]  hdr_type = '0;
  logic [31:0] hdr_src = '0;
  logic [31:0] hdr_dst = '0;
  logic [7:0]  hdr_seq = '0;
  logic [7:0]  hdr_len = '0;
  logic [7:0]  frame_sum = '0;
  logic [31:0] accept_count = '0;

  rfd_result_t frame_results_due[$];
  rfd_result_t want;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
    accepted_o   = 0;
  end

  task automatic clear_frame_state();
    frame_pos = '0;
    frame_xor = '0;
    hdr_type  = '0;
    hdr_src   = '0;
    hdr_dst   = '0;
    hdr_seq   = '0;
    hdr_len   = '0;
    frame_sum = '0;
  endtask

  task automatic deframe_byte(input logic [7:0] b, input logic fe);
    rfd_result_t r;
    int          pos;
    int          sum_pos;
    logic        is_payload;
    logic        bcast;
    rfd_status_e st;
    is_payload = 1'b0;
    pos        = int'(frame_pos);
    sum_pos    = int'(HDR_BYTES) + int'(hdr_len);
    if (pos < MAX_BYTES) begin
      if (pos == int'(POS_TYPE)) begin
        hdr_type = b;
      end else if (pos <= int'(POS_SRC3)) begin
        hdr_src[8*(int'(POS_SRC3)-pos) +: 8] = b;
      end else if (pos <= int'(POS_DST3)) begin
        hdr_dst[8*(int'(POS_DST3)-pos) +: 8] = b;
      end else if (pos == int'(POS_SEQ)) begin
        hdr_seq = b;
      end else if (pos == int'(POS_LEN)) begin
        hdr_len = b;
      end else if (pos < sum_pos) begin
        is_payload = 1'b1;
      end else if (pos == sum_pos) begin
        frame_sum = b;
      end
      if (pos < sum_pos) begin
        frame_xor ^= b;
      end
      frame_pos = frame_pos + 9'd1;
      if (is_payload) begin
        r              = '0;
        r.kind         = KIND_PAYLOAD;
        r.payload_byte = b;
        r.last_of_run  = !fe;
        frame_results_due.push_back(r);
      end
    end
    if (fe) begin
      bcast = (hdr_dst == BCAST_ADDR);
      if (int'(frame_pos) < int'(MIN_FRAME_BYTES)) begin
        st = ST_TOO_SHORT;
      end else if (int'(frame_pos) < int'(MIN_FRAME_BYTES) + int'(hdr_len)) begin
        st = ST_TRUNCATED;
      end else if (frame_xor != frame_sum) begin
        st = ST_BAD_CHECKSUM;
      end else if (hdr_dst != node_addr && !bcast) begin
        st = ST_WRONG_DEST;
      end else begin
        st = ST_ACCEPTED;
      end
      if (st == ST_ACCEPTED) begin
        accept_count = accept_count + 32'd1;
        accepted_o++;
      end
      r                 = '0;
      r.kind            = KIND_STATUS;
      r.frame_status    = st;
      r.frame_type      = hdr_type;
      r.source_address  = hdr_src;
      r.sequence_number = hdr_seq;
      r.payload_length  = hdr_len;
      r.is_broadcast    = bcast;
      r.accepted_frames = accept_count;
      r.last_of_run     = 1'b1;
      frame_results_due.push_back(r);
      clear_frame_state();
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (fail_count_o < 40) begin
      $display("rfd_frame_checker: %s", msg);
    end
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val) begin
      report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                checked_o, name, got, exp_val));
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      node_addr    = '0;
      accept_count = '0;
      clear_frame_state();
      frame_results_due.delete();
    end else begin
      if (in_valid_i && !in_stall_o) begin
        deframe_byte(rx_byte_i, frame_end_i);
      end
      if (out_valid_o && !out_stall_i) begin
        if (frame_results_due.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing pending", checked_o));
        end else begin
          want = frame_results_due.pop_front();
          check_field("kind", 32'(kind_o), 32'(want.kind));
          check_field("payload_byte", 32'(payload_byte_o), 32'(want.payload_byte));
          check_field("frame_status", 32'(frame_status_o), 32'(want.frame_status));
          check_field("frame_type", 32'(frame_type_o), 32'(want.frame_type));
          check_field("source_address", source_address_o, want.source_address);
          check_field("sequence_number", 32'(sequence_number_o),
                      32'(want.sequence_number));
          check_field("payload_length", 32'(payload_length_o), 32'(want.payload_length));
          check_field("is_broadcast", 32'(is_broadcast_o), 32'(want.is_broadcast));
          check_field("accepted_frames", accepted_frames_o, want.accepted_frames);
          check_field("last_of_run", 32'(last_of_run_o), 32'(want.last_of_run));
        end
        checked_o++;
      end
      if (psel && penable && pwrite && pready && paddr == NODE_ADDR_OFFSET) begin
        node_addr = pwdata;
      end
    end
    pending_o = frame_results_due.size();
  end

endmodule

// File: dv/tb_top.sv
module tb_top;
  import rfd_pkg::*;

  localparam int CLK_PERIOD      = 8;
  localparam int MAX_FRAME_BYTES = 256;
  localparam int RANDOM_BYTES    = 1550;
  localparam int NUM_SETTINGS    = 5;
  localparam logic [2:0] NODE_ADDR_OFFSET = {REG_NODE_ADDR, 2'b00};

  typedef enum {
    FK_GOOD, FK_BAD_SUM, FK_TRAILING, FK_SHORT, FK_CUT, FK_OVERSIZE, FK_NOISE
  } frame_kind_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i = '0;
  logic        frame_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        kind_o;
  logic [7:0]  payload_byte_o;
  logic [2:0]  frame_status_o;
  logic [7:0]  frame_type_o;
  logic [31:0] source_address_o;
  logic [7:0]  sequence_number_o;
  logic [7:0]  payload_length_o;
  logic        is_broadcast_o;
  logic [31:0] accepted_frames_o;
  logic        last_of_run_o;

  int fail_count;
  int pending;
  int checked;
  int accepted;

  logic [31:0] node_addr = '0;
  int          bytes_sent = 0;
  int          frames_sent = 0;
  int          burst_left = 0;
  int          settings_used = 0;
  logic        long_hold_done = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  radio_frame_deframer #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) DUT (.*);

  rfd_frame_checker #(.MAX_BYTES(MAX_FRAME_BYTES)) u_checker (
    .*,
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .accepted_o  (accepted)
  );

  task automatic offer_beat(input logic [7:0] b, input logic fe);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    rx_byte_i   <= b;
    frame_end_i <= fe;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
  endtask

  task automatic send_bytes(input logic [7:0] fb[$]);
    foreach (fb[i]) begin
      offer_beat(fb[i], i == fb.size() - 1);
    end
    frames_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_node_address(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= NODE_ADDR_OFFSET;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    node_addr = value;
    settings_used++;
  endtask

  task automatic send_frame(input frame_kind_e fk);
    logic [7:0]  fb[$];
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  len;
    logic [7:0]  sum;
    int          keep;
    src = $urandom;
    case ($urandom_range(0, 5))
      0, 1: dst = node_addr;
      2: dst = BCAST_ADDR;
      3: dst = node_addr ^ (32'h1 << $urandom_range(0, 31));
      default: dst = $urandom;
    endcase
    len = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(13, 244))
                                       : 8'($urandom_range(0, 12));
    if (fk == FK_OVERSIZE) len = 8'($urandom_range(230, 255));
    if (fk == FK_CUT && len == 0) len = 8'd1;
    fb.push_back(8'($urandom));
    for (int i = 3; i >= 0; i--) fb.push_back(src[8*i +: 8]);
    for (int i = 3; i >= 0; i--) fb.push_back(dst[8*i +: 8]);
    fb.push_back(8'($urandom));
    fb.push_back(len);
    repeat (len) fb.push_back(8'($urandom));
    sum = '0;
    foreach (fb[i]) sum ^= fb[i];
    if (fk == FK_BAD_SUM) sum ^= 8'(1 << $urandom_range(0, 7));
    fb.push_back(sum);
    case (fk)
      FK_TRAILING: begin
        repeat ($urandom_range(1, 8)) fb.push_back(8'($urandom));
      end
      FK_SHORT: begin
        keep = $urandom_range(1, 11);
        while (fb.size() > keep) void'(fb.pop_back());
      end
      FK_CUT: begin
        keep = $urandom_range(12, 11 + int'(len));
        while (fb.size() > keep) void'(fb.pop_back());
      end
      FK_OVERSIZE: begin
        keep = MAX_FRAME_BYTES + $urandom_range(1, 12);
        while (fb.size() < keep) fb.push_back(8'($urandom));
      end
      FK_NOISE: begin
        fb.delete();
        repeat ($urandom_range(1, 30)) fb.push_back(8'($urandom));
      end
      default: ;
    endcase
    send_bytes(fb);
  endtask

  function automatic frame_kind_e pick_frame_kind();
    int r;
    r = $urandom_range(0, 63);
    if (r == 0) return FK_OVERSIZE;
    if (r <= 4) return FK_NOISE;
    if (r <= 9) return FK_SHORT;
    if (r <= 15) return FK_CUT;
    if (r <= 21) return FK_BAD_SUM;
    if (r <= 27) return FK_TRAILING;
    return FK_GOOD;
  endfunction

  initial begin : receive_side
    int seg_len;
    int seg_mode;
    @(posedge clk_i);
    forever begin
      seg_mode = $urandom_range(0, 15);
      if (!long_hold_done && bytes_sent > 300) begin
        long_hold_done = 1'b1;
        seg_mode = 0;
      end
      seg_len = (seg_mode == 0) ? $urandom_range(120, 200) : $urandom_range(5, 60);
      for (int c = 0; c < seg_len; c++) begin
        if (seg_mode == 0) begin
          out_stall_i <= 1'b1;
        end else if (seg_mode <= 3) begin
          out_stall_i <= 1'b0;
        end else if (seg_mode <= 9) begin
          out_stall_i <= 1'($urandom_range(0, 1));
        end else begin
          out_stall_i <= ($urandom_range(0, 3) == 0);
        end
        @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    #(CLK_PERIOD * 400000);
    $display("tb_top: errors");
    $finish;
  end

  initial begin : stimulus
    logic [7:0]  fb[$];
    logic [31:0] setting;
    int          base_bytes;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    fb = {8'hFF};
    send_bytes(fb);
    fb = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
          8'h00, 8'h00};
    send_bytes(fb);
    fb = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h01, 8'hA5};
    send_bytes(fb);
    base_bytes = bytes_sent;

    for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
      wait_drained();
      case (ph)
        1: setting = 32'hFFFF_FFFF;
        2: setting = 32'h0000_0000;
        4: setting = 32'h0000_0001;
        default: setting = $urandom;
      endcase
      write_node_address(setting);
      if (ph == 1) send_frame(FK_OVERSIZE);
      while (bytes_sent < base_bytes + RANDOM_BYTES * (ph + 1) / NUM_SETTINGS) begin
        send_frame(pick_frame_kind());
        if ($urandom_range(0, 19) == 0) wait_drained();
      end
    end
    wait_drained();

    $display("tb_top: %0d bytes in %0d frames across %0d node address settings",
             bytes_sent, frames_sent, settings_used);
    $display("tb_top: %0d results checked, %0d frames accepted, long output hold %0s",
             checked, accepted, long_hold_done ? "done" : "missed");
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
